[design/fpba_pkg.sv]
// Shared types, register indexes and policy codes of the fit-policy block allocator.
package fpba_pkg;

  localparam int unsigned MaxBlocksDef = 64;
  localparam int unsigned SizeBitsDef  = 31;

  localparam int unsigned AddrW   = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PolicyW = 2;

  typedef logic [AddrW-3:0] reg_idx_t;

  localparam reg_idx_t RegPolicyMode = 1'b0;
  localparam reg_idx_t RegBlockCount = 1'b1;

  typedef enum logic [PolicyW-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_NEXT  = 2'd3
  } policy_e;

  // Control of the candidate tracker during a scan.
  typedef struct packed {
    logic    clear;
    logic    sample;
    policy_e policy;
  } pick_ctl_t;

endpackage

[design/fpba_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module fpba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/fpba_cfg.sv]
// Configuration registers of the allocator behind an APB-style port.
module fpba_cfg #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::MaxBlocksDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [fpba_pkg::AddrW-1:0]     paddr,
  input  logic [fpba_pkg::DataW-1:0]     pwdata,
  output logic [fpba_pkg::DataW-1:0]     prdata,
  output logic                           pready,
  output fpba_pkg::policy_e              policy_o,
  output logic [$clog2(MAX_BLOCKS+1)-1:0] block_count_o
);
  import fpba_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  policy_e         policy_q, policy_d;
  logic [CntW-1:0] count_q, count_d;
  reg_idx_t        reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    policy_d = policy_q;
    count_d  = count_q;
    if (wr_en) begin
      unique case (reg_idx)
        RegPolicyMode: policy_d = policy_e'(pwdata[PolicyW-1:0]);
        RegBlockCount: count_d  = pwdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegPolicyMode: prdata = DataW'(policy_q);
      RegBlockCount: prdata = DataW'(count_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FIRST;
      count_q  <= CntW'(MAX_BLOCKS);
    end else begin
      policy_q <= policy_d;
      count_q  <= count_d;
    end
  end

  assign policy_o      = policy_q;
  assign block_count_o = count_q;

endmodule

[design/fpba_pick.sv]
// Candidate tracker: keeps the block chosen so far while the table is scanned.
module fpba_pick #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::MaxBlocksDef,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fpba_pkg::pick_ctl_t           ctl_i,
  input  logic [SIZE_BITS-1:0]          req_i,
  input  logic [SIZE_BITS-1:0]          data_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] idx_i,
  output logic                          have_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] idx_o,
  output logic [SIZE_BITS-1:0]          size_o
);
  import fpba_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);

  logic                 have_q, have_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic                 fits, better;

  // The request is common to all candidates, so comparing the leftovers
  // is the same as comparing the sizes themselves.
  assign fits = (data_i >= req_i);

  always_comb begin
    unique case (ctl_i.policy)
      POL_BEST:  better = !have_q || (data_i < size_q);
      POL_WORST: better = !have_q || (data_i > size_q);
      default:   better = !have_q;
    endcase
  end

  always_comb begin
    have_d = have_q;
    idx_d  = idx_q;
    size_d = size_q;
    if (ctl_i.clear) begin
      have_d = 1'b0;
    end else if (ctl_i.sample && fits && better) begin
      have_d = 1'b1;
      idx_d  = idx_i;
      size_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else begin
      have_q <= have_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    size_q <= size_d;
  end

  assign have_o = have_q;
  assign idx_o  = idx_q;
  assign size_o = size_q;

endmodule

[design/fit_policy_block_allocator_top.sv]
// Top level of the fit-policy block allocator: sequencer, table memory and result register.
// A load item is written to the table at the edge that accepts it.
// An allocate item passes through a start state, one table read per block of the effective count
// (block_count capped at MAX_BLOCKS), a drain state and a write-back state before the next item
// is accepted. A count of zero skips the start, the scan and the drain and goes to the write-back.
// In next fit the start state repeats, taking the count off the start position each time, when the
// last block used is the final counted block or beyond it; the write-back waits while the result register is held.
// Reset clears the control state, the last-block record and the result valid flag; the table has no clearing pass.
module fit_policy_block_allocator_top #(
  parameter int unsigned MAX_BLOCKS = fpba_pkg::MaxBlocksDef,
  parameter int unsigned SIZE_BITS  = fpba_pkg::SizeBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input item channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [$clog2(MAX_BLOCKS)-1:0] block_index_i,
  input  logic [SIZE_BITS-1:0]          size_value_i,
  // Result item channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [$clog2(MAX_BLOCKS)-1:0] chosen_block_o,
  output logic [SIZE_BITS-1:0]          size_before_o,
  output logic [SIZE_BITS-1:0]          fragment_left_o,
  output logic [SIZE_BITS-1:0]          request_size_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpba_pkg::AddrW-1:0]    paddr,
  input  logic [fpba_pkg::DataW-1:0]    pwdata,
  output logic [fpba_pkg::DataW-1:0]    prdata,
  output logic                          pready
);
  import fpba_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PREP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpAlloc = 1'b1;

  policy_e              policy;
  logic [CntW-1:0]      block_count;
  logic [CntW-1:0]      eff_count;

  logic [2:0]           state_q, state_d;
  logic [SIZE_BITS-1:0] req_q, req_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      pos_q, pos_d;
  logic [CntW-1:0]      issued_q, issued_d;
  logic                 rd_pend_q, rd_pend_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]      last_q, last_d;
  logic                 last_valid_q, last_valid_d;

  logic                 in_acc, alloc_acc, load_acc;
  logic                 out_free, fin_fire;

  logic                 ram_we;
  logic [IdxW-1:0]      ram_waddr, ram_raddr;
  logic [SIZE_BITS-1:0] ram_wdata, ram_rdata;

  pick_ctl_t            pick_ctl;
  logic                 pick_have;
  logic [IdxW-1:0]      pick_idx;
  logic [SIZE_BITS-1:0] pick_size;
  logic [SIZE_BITS-1:0] frag;

  logic                 out_valid_q, out_valid_d;
  logic                 found_q;
  logic [IdxW-1:0]      chosen_q;
  logic [SIZE_BITS-1:0] before_q, left_q, echo_q;

  fpba_cfg #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .policy_o      (policy),
    .block_count_o (block_count)
  );

  // A count above the table depth is taken as the whole table.
  assign eff_count = (block_count > CntW'(MAX_BLOCKS)) ? CntW'(MAX_BLOCKS) : block_count;

  // Only one item is in work at a time, so the write-back of an allocate and
  // the reads of the following item never overlap on the same entry.
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (op_i == OpLoad) &&
                      (CntW'(block_index_i) < CntW'(MAX_BLOCKS));
  assign alloc_acc  = in_acc && (op_i == OpAlloc);

  // The result register parts the two channels: a new result may be loaded
  // in the same cycle as the previous one is taken.
  assign out_free = !out_valid_q || !out_stall_i;
  assign fin_fire = (state_q == S_FIN) && out_free;

  assign frag = pick_size - req_q;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    issued_d     = issued_q;
    last_d       = last_q;
    last_valid_d = last_valid_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = pos_q[IdxW-1:0];
    ram_raddr    = pos_q[IdxW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (alloc_acc) begin
          req_d    = size_value_i;
          cnt_d    = eff_count;
          issued_d = '0;
          // Next fit resumes just after the last block used; every other
          // policy scans from block zero.
          if (policy == POL_NEXT && last_valid_q) begin
            pos_d = CntW'(last_q) + CntW'(1);
          end else begin
            pos_d = '0;
          end
          state_d = (eff_count == '0) ? S_FIN : S_PREP;
        end
      end
      S_PREP: begin
        // Brings the start position below the count by repeated subtraction.
        if (pos_q >= cnt_q) begin
          pos_d = pos_q - cnt_q;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_pend_d = 1'b1;
        pos_d     = (pos_q + CntW'(1) == cnt_q) ? '0 : pos_q + CntW'(1);
        issued_d  = issued_q + CntW'(1);
        if (issued_q == cnt_q - CntW'(1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          if (pick_have) begin
            last_d       = pick_idx;
            last_valid_d = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Table writes come from a load in idle or from the write-back of an allocate.
  always_comb begin
    if (state_q == S_FIN) begin
      ram_we    = fin_fire && pick_have;
      ram_waddr = pick_idx;
      ram_wdata = frag;
    end else begin
      ram_we    = load_acc;
      ram_waddr = block_index_i;
      ram_wdata = size_value_i;
    end
  end

  fpba_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read data arrives in the cycle after its address and is judged then; the scan
  // order makes the first block met win every tie.
  assign pick_ctl.clear  = alloc_acc;
  assign pick_ctl.sample = rd_pend_q;
  assign pick_ctl.policy = policy;

  fpba_pick #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .SIZE_BITS (SIZE_BITS)
  ) u_pick (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (pick_ctl),
    .req_i  (req_q),
    .data_i (ram_rdata),
    .idx_i  (rd_idx_q),
    .have_o (pick_have),
    .idx_o  (pick_idx),
    .size_o (pick_size)
  );

  assign out_valid_d = fin_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rd_pend_q    <= 1'b0;
      last_q       <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_pend_q    <= rd_pend_d;
      last_q       <= last_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    cnt_q    <= cnt_d;
    pos_q    <= pos_d;
    issued_q <= issued_d;
    rd_idx_q <= rd_idx_d;
    if (fin_fire) begin
      found_q  <= pick_have;
      chosen_q <= pick_have ? pick_idx : '0;
      before_q <= pick_have ? pick_size : '0;
      left_q   <= pick_have ? frag : '0;
      echo_q   <= req_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign chosen_block_o  = chosen_q;
  assign size_before_o   = before_q;
  assign fragment_left_o = left_q;
  assign request_size_o  = echo_q;

`ifndef SYNTH
  a_write_when_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_IDLE || state_q == S_FIN))
    else $error("table written outside idle or write-back");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (pos_q < cnt_q))
    else $error("scan address beyond the block count");

  a_fragment_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |->
      (size_before_o >= request_size_o &&
       fragment_left_o == size_before_o - request_size_o))
    else $error("fragment does not match size before and request");

  a_not_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |->
      (chosen_block_o == '0 && size_before_o == '0 && fragment_left_o == '0))
    else $error("not-found result carries non-zero fields");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_fire |=> (out_valid_o && state_q == S_IDLE))
    else $error("write-back did not present a result");
`endif

endmodule

[verif/testbench.sv]
// Self-checking testbench for the fit-policy block allocator, with its own prediction of each grant.
`timescale 1ns / 100ps

module testbench;
  import fpba_pkg::*;

  localparam int unsigned MaxBlocks = MaxBlocksDef;
  localparam int unsigned SizeBits  = SizeBitsDef;
  localparam int unsigned IdxBits   = $clog2(MaxBlocks);

  // Operation codes of an input item.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpAlloc = 1'b1;

  localparam logic [SizeBits-1:0] SizeMax = '1;

  typedef struct packed {
    logic                op;
    logic [IdxBits-1:0]  idx;
    logic [SizeBits-1:0] size;
  } table_cmd_t;

  typedef struct packed {
    logic                found;
    logic [IdxBits-1:0]  chosen;
    logic [SizeBits-1:0] prior;
    logic [SizeBits-1:0] remain;
    logic [SizeBits-1:0] request;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                op_i = OpLoad;
  logic [IdxBits-1:0]  block_index_i = '0;
  logic [SizeBits-1:0] size_value_i = '0;

  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                found_o;
  logic [IdxBits-1:0]  chosen_block_o;
  logic [SizeBits-1:0] size_before_o;
  logic [SizeBits-1:0] fragment_left_o;
  logic [SizeBits-1:0] request_size_o;

  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Predicted state of the allocator and its registers.
  logic [SizeBits-1:0] free_size [MaxBlocks];
  int unsigned         last_block = 0;
  logic                last_ok = 1'b0;
  policy_e             cfg_policy = POL_FIRST;
  int unsigned         cfg_count = MaxBlocks;

  table_cmd_t cmd_queue[$];
  grant_t     predicted_grants[$];
  int         errors = 0;

  // Long quiet stretches on either side are switched per phase.
  logic in_burst = 1'b0;
  logic out_burst = 1'b0;

  always #10 clk_i = ~clk_i;

  fit_policy_block_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .block_index_i   (block_index_i),
    .size_value_i    (size_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .found_o         (found_o),
    .chosen_block_o  (chosen_block_o),
    .size_before_o   (size_before_o),
    .fragment_left_o (fragment_left_o),
    .request_size_o  (request_size_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Applies one accepted item to the predicted table; an allocate adds one predicted grant.
  task automatic apply_to_table(input logic op, input logic [IdxBits-1:0] idx,
                                input logic [SizeBits-1:0] size);
    grant_t              g;
    int unsigned         cnt;
    int unsigned         start;
    int unsigned         i;
    logic [SizeBits-1:0] left;
    logic [SizeBits-1:0] best_left;
    g = '0;
    best_left = '0;
    if (op == OpLoad) begin
      free_size[idx] = size;
    end else begin
      cnt = (cfg_count > MaxBlocks) ? MaxBlocks : cfg_count;
      g.request = size;
      if (cfg_policy == POL_NEXT) begin
        // Circular search that begins just after the last block used.
        start = (last_ok && cnt != 0) ? (last_block + 1) % cnt : 0;
        for (int unsigned k = 0; k < cnt; k++) begin
          i = (start + k) % cnt;
          if (!g.found && free_size[i] >= size) begin
            g.found = 1'b1;
            g.chosen = i[IdxBits-1:0];
          end
        end
      end else begin
        for (int unsigned k = 0; k < cnt; k++) begin
          if (free_size[k] >= size) begin
            left = free_size[k] - size;
            if (!g.found || (cfg_policy == POL_BEST && left < best_left) ||
                (cfg_policy == POL_WORST && left > best_left)) begin
              g.found = 1'b1;
              g.chosen = k[IdxBits-1:0];
              best_left = left;
            end
          end
        end
      end
      if (g.found) begin
        g.prior = free_size[g.chosen];
        g.remain = g.prior - size;
        free_size[g.chosen] = g.remain;
        last_block = g.chosen;
        last_ok = 1'b1;
      end
      predicted_grants.push_back(g);
    end
  endtask

  task automatic check_field(input string what, input logic [SizeBits-1:0] want,
                             input logic [SizeBits-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // Sender: one item at a time from cmd_queue, with a random gap after each acceptance unless in_burst is set.
  int unsigned send_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    logic       busy;
    table_cmd_t c;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      send_gap = 0;
    end else begin
      busy = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        apply_to_table(op_i, block_index_i, size_value_i);
        busy = 1'b0;
        send_gap = in_burst ? 0 : $urandom_range(0, 12);
      end
      if (!busy) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_queue.size() != 0) begin
          c = cmd_queue.pop_front();
          op_i <= c.op;
          block_index_i <= c.idx;
          size_value_i <= c.size;
          busy = 1'b1;
        end
      end
      in_valid_i <= busy;
    end
  end

  // Receiver: after each result it holds stall until the next result has waited a drawn time, unless out_burst is set.
  int unsigned hold_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_grants.size() == 0) begin
          $display("%0t: unexpected result, block %0d found %0b", $time, chosen_block_o,
                   found_o);
          errors++;
        end else begin
          g = predicted_grants.pop_front();
          check_field("found", SizeBits'(g.found), SizeBits'(found_o));
          check_field("chosen_block", SizeBits'(g.chosen), SizeBits'(chosen_block_o));
          check_field("size_before", g.prior, size_before_o);
          check_field("fragment_left", g.remain, fragment_left_o);
          check_field("request_size", g.request, request_size_o);
        end
        hold_left = out_burst ? 0 : $urandom_range(0, 12);
      end else if (out_valid_o && hold_left > 0) begin
        hold_left--;
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  task automatic write_reg(input reg_idx_t which, input int unsigned value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    // The register takes the value at this edge.
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (which)
      RegPolicyMode: cfg_policy = policy_e'(value[PolicyW-1:0]);
      RegBlockCount: cfg_count = value & 32'h7f;
      default: ;
    endcase
  endtask

  // Items are handed over one by one, so generation sees an almost current table.
  task automatic queue_item(input logic op, input int unsigned idx,
                            input logic [SizeBits-1:0] size);
    table_cmd_t c;
    while (cmd_queue.size() != 0) @(posedge clk_i);
    c.op = op;
    c.idx = idx[IdxBits-1:0];
    c.size = size;
    cmd_queue.push_back(c);
  endtask

  // Waits until nothing is in flight, then lets a full scan's worth of cycles pass.
  task automatic settle();
    while (cmd_queue.size() != 0 || in_valid_i || predicted_grants.size() != 0)
      @(posedge clk_i);
    repeat (2 * MaxBlocks + 16) @(posedge clk_i);
  endtask

  function automatic logic [SizeBits-1:0] draw_size();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SizeMax;
      2: return SizeBits'($urandom());
      3: return SizeBits'($urandom_range(0, 15));
      default: return SizeBits'($urandom_range(0, 1000));
    endcase
  endfunction

  function automatic logic [SizeBits-1:0] draw_request();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SizeMax;
      2, 3: return free_size[$urandom_range(0, cfg_count - 1)];
      4: return free_size[$urandom_range(0, cfg_count - 1)] + 1'b1;
      5: return SizeBits'($urandom());
      default: return SizeBits'($urandom_range(0, 400));
    endcase
  endfunction

  int unsigned phase_counts [16] = '{64, 1, 64, 2, 1, 64, 1, 33, 64, 5, 64, 1, 48, 64, 3, 64};

  initial begin
    policy_e pol;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on a four-block table.
    write_reg(RegPolicyMode, POL_FIRST);
    write_reg(RegBlockCount, 4);
    queue_item(OpLoad, 0, 10);
    queue_item(OpLoad, 1, SizeMax);
    queue_item(OpLoad, 2, 0);
    queue_item(OpLoad, 3, 10);
    queue_item(OpLoad, 63, 31'h2aaaaaaa);
    queue_item(OpAlloc, 0, 0);          // a zero request leaves the block unchanged
    queue_item(OpAlloc, 0, SizeMax);    // only the full block fits, nothing is left
    queue_item(OpAlloc, 0, SizeMax);    // nothing fits now
    queue_item(OpAlloc, 63, 4);
    settle();
    write_reg(RegPolicyMode, POL_BEST);
    queue_item(OpLoad, 2, 5);
    queue_item(OpAlloc, 0, 5);          // exact fit wins
    queue_item(OpAlloc, 0, 6);
    settle();
    write_reg(RegPolicyMode, POL_WORST);
    queue_item(OpLoad, 0, 9);
    queue_item(OpLoad, 1, 9);
    queue_item(OpAlloc, 0, 2);          // worst fit picks block 3, the largest free block
    settle();
    write_reg(RegPolicyMode, POL_NEXT);
    queue_item(OpLoad, 3, 20);
    queue_item(OpAlloc, 0, 3);
    queue_item(OpAlloc, 0, 15);
    settle();
    // The last block used now lies beyond the count, so the start wraps.
    write_reg(RegBlockCount, 2);
    queue_item(OpAlloc, 0, 1);
    queue_item(OpAlloc, 0, 1);
    settle();

    // Random part: every policy in turn over a range of block counts.
    pol = POL_FIRST;
    for (int p = 0; p < 16; p++) begin
      write_reg(RegPolicyMode, pol);
      write_reg(RegBlockCount, phase_counts[p]);
      in_burst = ($urandom_range(0, 3) == 0);
      out_burst = ($urandom_range(0, 3) == 0);
      // Every entry is loaded once before any allocate at the full count.
      if (p == 0)
        for (int b = 0; b < MaxBlocks; b++) queue_item(OpLoad, b, draw_size());
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 99) < 30)
          queue_item(OpLoad, ($urandom_range(0, 3) == 0) ? $urandom_range(0, MaxBlocks - 1)
                                                         : $urandom_range(0, cfg_count - 1),
                     draw_size());
        else
          queue_item(OpAlloc, $urandom_range(0, MaxBlocks - 1), draw_request());
      end
      settle();
      pol = pol.next();
    end

    if (errors == 0 && predicted_grants.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
